// ===== hdl/vertex_transform_perspective_divide_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VTPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtpd assertion failed");

// Next-cycle implication, checked during reset as well.
`define VTPD_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vtpd assertion failed");

`endif

// ===== hdl/vtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths and pipeline payload types shared by the transform modules.
// ----------------------------------------------------------------------------
package vtpd_pkg;

   localparam int SUM_W   = 50;
   localparam int REM_W   = SUM_W;
   localparam int QUO_W   = 32;
   localparam int COORD_W = 32;
   localparam int COEF_W  = 16;
   localparam int LANES   = 3;

   localparam logic [1:0] CSR_ROW_0 = 2'd0;
   localparam logic [1:0] CSR_ROW_1 = 2'd1;
   localparam logic [1:0] CSR_ROW_2 = 2'd2;
   localparam logic [1:0] CSR_ROW_3 = 2'd3;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [QUO_W-1:0] low;
      logic             neg;
      logic             sgn;
      logic             nz;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [REM_W-1:0]     den;
      logic                 w_zero;
      logic                 last;
   } item_type;

endpackage

// ===== hdl/vtpd_div_step.sv =====
// ----------------------------------------------------------------------------
// Division step stage
// Retires one quotient bit for each of the three lanes and registers it.
// ----------------------------------------------------------------------------
module vtpd_div_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  vtpd_pkg::item_type in_item,
   output logic               out_valid,
   output vtpd_pkg::item_type out_item
);
   import vtpd_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      logic [REM_W-1:0] r;
      item_in = in_item;
      for (int i = 0; i < LANES; i++) begin
         r = {in_item.lane[i].rem[REM_W-2:0], in_item.lane[i].low[QUO_W-1]};
         item_in.lane[i].low = {in_item.lane[i].low[QUO_W-2:0], 1'b0};
         if (r >= in_item.den) begin
            item_in.lane[i].rem = r - in_item.den;
            item_in.lane[i].quo = {in_item.lane[i].quo[QUO_W-2:0], 1'b1};
         end else begin
            item_in.lane[i].rem = r;
            item_in.lane[i].quo = {in_item.lane[i].quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== hdl/vertex_transform_perspective_divide.sv =====
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Stages from request to result: multiply, sum, magnitude, range check,
// 32 division steps and the saturating output register. Throughput is one
// request per cycle; the whole pipeline stalls together while a result
// waits. Reset clears all valid bits and loads the identity.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide #(
   parameter int COEF_FRAC_BITS  = 8,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // pos_x, pos_y, pos_z
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // proj_x, proj_y, proj_z
   output logic [1:0]   rsp_tuser,   // w_zero, clipped
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import vtpd_pkg::*;

   localparam int NUM_W = SUM_W + COORD_FRAC_BITS;
   localparam int PROD_W = COEF_W + COORD_W;

   logic [63:0] row_ff [4];
   logic        en;

   logic                      v1_ff;
   logic signed [PROD_W-1:0]  prod_ff [4][3];
   logic signed [COEF_W-1:0]  coef3_ff [4];
   logic                      last1_ff;

   logic                      v2_ff;
   logic signed [SUM_W-1:0]   sum_ff [4];
   logic                      last2_ff;

   logic     v3_ff, v4_ff;
   item_type item3_ff, item3_in, item4_ff, item4_in;

   logic     vld [QUO_W+1];
   item_type stq [QUO_W+1];

   logic         rsp_valid_ff;
   logic [95:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;
   logic         rsp_last_ff;

   assign en         = rsp_tready || !rsp_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            row_ff[i] <= 64'((64'(1) << COEF_FRAC_BITS) << (16 * i));
         end
      end else if (csr_valid && csr_index < 8'd4) begin
         case (csr_index[1:0])
            CSR_ROW_0: row_ff[0] <= csr_data;
            CSR_ROW_1: row_ff[1] <= csr_data;
            CSR_ROW_2: row_ff[2] <= csr_data;
            CSR_ROW_3: row_ff[3] <= csr_data;
            default:   row_ff[0] <= row_ff[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= $signed(row_ff[i][16*j +: 16]) *
                                $signed(req_tdata[32*j +: 32]);
            end
            coef3_ff[i] <= $signed(row_ff[i][63:48]);
         end
         last1_ff <= req_tlast;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1]) +
                         SUM_W'(prod_ff[i][2]) +
                         (SUM_W'(coef3_ff[i]) <<< COORD_FRAC_BITS);
         end
         last2_ff <= last1_ff;
         item3_ff <= item3_in;
         item4_ff <= item4_in;
      end
   end

   always_comb begin
      logic [SUM_W-1:0] m;
      logic [NUM_W-1:0] n;
      item3_in = '0;
      item3_in.den    = sum_ff[3][SUM_W-1] ? SUM_W'(-sum_ff[3]) : SUM_W'(sum_ff[3]);
      item3_in.w_zero = (sum_ff[3] == '0);
      item3_in.last   = last2_ff;
      for (int i = 0; i < LANES; i++) begin
         m = sum_ff[i][SUM_W-1] ? SUM_W'(-sum_ff[i]) : SUM_W'(sum_ff[i]);
         n = {m, {COORD_FRAC_BITS{1'b0}}};
         item3_in.lane[i].rem = REM_W'(n[NUM_W-1:QUO_W]);
         item3_in.lane[i].low = n[QUO_W-1:0];
         item3_in.lane[i].sgn = sum_ff[i][SUM_W-1];
         item3_in.lane[i].nz  = (sum_ff[i] != '0);
         item3_in.lane[i].neg = sum_ff[i][SUM_W-1] ^ sum_ff[3][SUM_W-1];
      end
   end

   always_comb begin
      item4_in = item3_ff;
      for (int i = 0; i < LANES; i++) begin
         item4_in.lane[i].ovf = (item3_ff.lane[i].rem >= item3_ff.den);
      end
   end

   assign vld[0] = v4_ff;
   assign stq[0] = item4_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      vtpd_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (vld[k]),
         .in_item   (stq[k]),
         .out_valid (vld[k+1]),
         .out_item  (stq[k+1])
      );
   end

   always_comb begin
      logic [31:0] q, lim, sat;
      logic        clip;
      clip = 1'b0;
      rsp_data_in = '0;
      for (int i = 0; i < LANES; i++) begin
         q   = stq[QUO_W].lane[i].quo;
         lim = stq[QUO_W].lane[i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         sat = stq[QUO_W].lane[i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         if (stq[QUO_W].w_zero) begin
            if (!stq[QUO_W].lane[i].nz) begin
               rsp_data_in[32*i +: 32] = 32'h0;
            end else if (stq[QUO_W].lane[i].sgn) begin
               rsp_data_in[32*i +: 32] = 32'h8000_0000;
            end else begin
               rsp_data_in[32*i +: 32] = 32'h7FFF_FFFF;
            end
         end else if (stq[QUO_W].lane[i].ovf || q > lim) begin
            rsp_data_in[32*i +: 32] = sat;
            clip = 1'b1;
         end else begin
            rsp_data_in[32*i +: 32] = stq[QUO_W].lane[i].neg ? 32'(-q) : q;
         end
      end
      rsp_user_in = {clip && !stq[QUO_W].w_zero, stq[QUO_W].w_zero};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= stq[QUO_W].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ===== hdl/vtpd_checker.sv =====
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Watches the top-level ports and flags handshake and flag slips.
// ----------------------------------------------------------------------------
`include "vertex_transform_perspective_divide_defines.svh"

module vtpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_ready
);
   `VTPD_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_tvalid)
   `VTPD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `VTPD_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   `VTPD_ASSERT_NEXT(a_stall_holds, clock, !reset && rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && (rsp_tvalid || reset) && csr_ready)
endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
